// File: design/mlft_pkg.sv
package mlft_pkg;

	localparam int DEF_TABLE_ENTRIES = 64;
	localparam int DEF_NUM_PORTS     = 8;

	localparam int MAC_W      = 48;
	localparam int PORT_W     = 3;
	localparam int TICK_W     = 32;
	localparam int AGING_W    = 31;
	localparam int MASK_W     = 8;
	localparam int GROUP_BIT  = 40;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [AGING_W-1:0] AGING_RESET = AGING_W'(300);
	localparam logic [MASK_W-1:0]  PORTS_RESET = 8'hFF;

	// Register index as decoded from paddr[2].
	localparam logic REG_AGING = 1'b0;
	localparam logic REG_PORTS = 1'b1;

	typedef enum logic [1:0] {
		DEC_FORWARD = 2'd0,
		DEC_FLOOD   = 2'd1,
		DEC_FILTER  = 2'd2
	} decision_t;

	typedef struct packed {
		logic [MAC_W-1:0]  src_mac;
		logic [MAC_W-1:0]  dst_mac;
		logic [PORT_W-1:0] ingress_port;
		logic [TICK_W-1:0] now_ticks;
	} frame_t;

	typedef struct packed {
		decision_t         decision;
		logic [MASK_W-1:0] egress_mask;
		logic              learn_skipped;
	} result_t;

	typedef struct packed {
		logic [AGING_W-1:0] aging_ticks;
		logic [MASK_W-1:0]  ports_present_mask;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [MAC_W-1:0]  mac;
		logic [PORT_W-1:0] port;
		logic [TICK_W-1:0] expiry;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: design/mac_learning_forward_table.sv
// MAC learning bridge forwarding table.
//
// A frame transfer on the frame channel carries the source and destination
// addresses, the ingress port and the current tick. The block learns the
// source into the table and then looks up the destination, and returns one
// result transfer with the decision (forward, flood or filter), the egress
// port mask and a flag that is set when the source could not be learned.
// Both channels use valid and ready; the APB-style port sets the aging time
// (address 0) and the mask of present ports (address 4).
//
// Each frame with a unicast destination takes two passes over the
// single-port table RAM, one read a cycle, and a frame with a group
// destination only the learn pass; the RAM port is what sets the latency.
// An expired hit adds a write that invalidates the entry, and a hit ends
// the lookup pass early. The next frame transfer is taken in the cycle
// after the result is loaded, even while that result still waits for the
// receiver; a stalled receiver holds a finished frame until the register frees.
// After reset the table is cleared with frame_ready low. Configuration
// writes are taken at any time but belong between frames.
module mac_learning_forward_table import mlft_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int NUM_PORTS     = DEF_NUM_PORTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               frame_valid,
	output logic               frame_ready,
	input  frame_t             frame,
	output logic               result_valid,
	input  logic               result_ready,
	output result_t            result
);

	localparam int AW = $clog2(TABLE_ENTRIES);

	cfg_t             cfg;
	logic             ram_we;
	logic [AW-1:0]    ram_addr;
	entry_t           ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	// Register file for aging time and present-port mask.
	mlft_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer: clear, learn scan, learn write, lookup scan, aging invalidate.
	mlft_engine #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.NUM_PORTS     (NUM_PORTS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame        (frame),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.ram_we       (ram_we),
		.ram_addr     (ram_addr),
		.ram_wdata    (ram_wdata),
		.ram_rdata    (entry_t'(ram_rdata))
	);

	// The table itself: valid bit, address, port and expiry in one word.
	mlft_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

endmodule

// File: design/mlft_ram.sv
module mlft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// File: design/mlft_cfg.sv
module mlft_cfg import mlft_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.aging_ticks        <= AGING_RESET;
			cfg_q.ports_present_mask <= PORTS_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_AGING: cfg_q.aging_ticks        <= pwdata[AGING_W-1:0];
				REG_PORTS: cfg_q.ports_present_mask <= pwdata[MASK_W-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_AGING: prdata = PDATA_W'(cfg_q.aging_ticks);
			REG_PORTS: prdata = PDATA_W'(cfg_q.ports_present_mask);
			default:   prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: design/mlft_engine.sv
module mlft_engine import mlft_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int NUM_PORTS     = DEF_NUM_PORTS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cfg_t                             cfg,
	input  logic                             frame_valid,
	output logic                             frame_ready,
	input  frame_t                           frame,
	output logic                             result_valid,
	input  logic                             result_ready,
	output result_t                          result,
	output logic                             ram_we,
	output logic [$clog2(TABLE_ENTRIES)-1:0] ram_addr,
	output entry_t                           ram_wdata,
	input  entry_t                           ram_rdata
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);
	localparam logic [MASK_W-1:0] ALL_PORTS =
		(NUM_PORTS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << NUM_PORTS) - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LEARN,
		ST_LWRITE,
		ST_LOOKUP,
		ST_EXPIRE,
		ST_FINISH
	} state_t;

	state_t            state_q;
	logic [AW:0]       rd_q;
	logic              chk_s1;
	logic [AW-1:0]     idx_s1;
	frame_t            frame_q;
	logic              hit_q, free_q, stale_q;
	logic [AW-1:0]     hit_idx_q, free_idx_q, stale_idx_q, exp_idx_q;
	logic              skipped_q;
	decision_t         dec_q;
	logic [PORT_W-1:0] port_q;
	logic              result_valid_q;
	result_t           result_q;

	logic              issue;
	logic [AW-1:0]     rd_idx;
	logic              dst_match;
	logic              slot_found;
	logic [AW-1:0]     slot;
	logic [MASK_W-1:0] mask;

	// An entry is live while the signed difference expiry - now is positive.
	function automatic logic is_live(logic [TICK_W-1:0] expiry, logic [TICK_W-1:0] now);
		logic [TICK_W-1:0] d;
		d = expiry - now;
		return (d != '0) && !d[TICK_W-1];
	endfunction

	function automatic logic [MASK_W-1:0] port_bit(logic [PORT_W-1:0] p);
		return (MASK_W'(1) << p) & ALL_PORTS;
	endfunction

	assign rd_idx     = rd_q[AW-1:0];
	assign issue      = (rd_q < (AW+1)'(TABLE_ENTRIES));
	assign dst_match  = ram_rdata.valid && (ram_rdata.mac == frame_q.dst_mac);
	assign slot_found = hit_q || free_q || stale_q;
	assign slot       = hit_q ? hit_idx_q : (free_q ? free_idx_q : stale_idx_q);

	always_comb begin
		case (dec_q)
			DEC_FORWARD: mask = port_bit(port_q);
			DEC_FILTER:  mask = '0;
			default:     mask = cfg.ports_present_mask & ALL_PORTS &
			                    ~port_bit(frame_q.ingress_port);
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = rd_idx;
		ram_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_LWRITE: begin
				ram_we           = slot_found;
				ram_addr         = slot;
				ram_wdata.valid  = 1'b1;
				ram_wdata.mac    = frame_q.src_mac;
				ram_wdata.port   = frame_q.ingress_port;
				ram_wdata.expiry = frame_q.now_ticks + TICK_W'(cfg.aging_ticks);
			end
			ST_EXPIRE: begin
				ram_we   = 1'b1;
				ram_addr = exp_idx_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			rd_q           <= '0;
			chk_s1         <= 1'b0;
			hit_q          <= 1'b0;
			free_q         <= 1'b0;
			stale_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && result_ready && state_q != ST_FINISH) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					rd_q <= rd_q + 1'b1;
					if (rd_idx == LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (frame_valid) begin
						frame_q   <= frame;
						rd_q      <= '0;
						chk_s1    <= 1'b0;
						hit_q     <= 1'b0;
						free_q    <= 1'b0;
						stale_q   <= 1'b0;
						state_q   <= ST_LEARN;
					end
				end
				ST_LEARN: begin
					if (issue) begin
						rd_q <= rd_q + 1'b1;
					end
					chk_s1 <= issue;
					idx_s1 <= rd_idx;
					if (chk_s1) begin
						if (ram_rdata.valid) begin
							if (ram_rdata.mac == frame_q.src_mac) begin
								if (!hit_q) begin
									hit_q     <= 1'b1;
									hit_idx_q <= idx_s1;
								end
							end else if (!stale_q &&
							             !is_live(ram_rdata.expiry, frame_q.now_ticks)) begin
								stale_q     <= 1'b1;
								stale_idx_q <= idx_s1;
							end
						end else if (!free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= idx_s1;
						end
						if (idx_s1 == LAST) begin
							state_q <= ST_LWRITE;
						end
					end
				end
				ST_LWRITE: begin
					skipped_q <= !slot_found;
					rd_q      <= '0;
					chk_s1    <= 1'b0;
					if (frame_q.dst_mac[GROUP_BIT]) begin
						dec_q   <= DEC_FLOOD;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (issue) begin
						rd_q <= rd_q + 1'b1;
					end
					chk_s1 <= issue;
					idx_s1 <= rd_idx;
					if (chk_s1) begin
						if (dst_match) begin
							if (is_live(ram_rdata.expiry, frame_q.now_ticks)) begin
								port_q  <= ram_rdata.port;
								dec_q   <= (ram_rdata.port == frame_q.ingress_port) ?
								           DEC_FILTER : DEC_FORWARD;
								state_q <= ST_FINISH;
							end else begin
								exp_idx_q <= idx_s1;
								dec_q     <= DEC_FLOOD;
								state_q   <= ST_EXPIRE;
							end
						end else if (idx_s1 == LAST) begin
							dec_q   <= DEC_FLOOD;
							state_q <= ST_FINISH;
						end
					end
				end
				ST_EXPIRE: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!result_valid_q || result_ready) begin
						result_valid_q         <= 1'b1;
						result_q.decision      <= dec_q;
						result_q.egress_mask   <= mask;
						result_q.learn_skipped <= skipped_q;
						state_q                <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign frame_ready  = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: sim/tb.sv
module tb;
	import mlft_pkg::*;

	// The table is checked at its default geometry.
	localparam int TABLE_ENTRIES = DEF_TABLE_ENTRIES;
	localparam int NUM_PORTS     = DEF_NUM_PORTS;

	// The run is bounded by a free-running cycle counter. A correct run
	// handles about a thousand frames, and the limit leaves several times
	// the time that they need, including the table clear after reset.
	localparam int CYCLE_LIMIT = 1_000_000;

	// After the last result, allow a bit more than one full frame of work so
	// that any stray extra result transfer would still be seen.
	localparam int TAIL_CYCLES = 2 * TABLE_ENTRIES + 16;

	localparam logic [MAC_W-1:0] BCAST_MAC = '1;

	// Ports that exist in this configuration of the block.
	localparam logic [MASK_W-1:0] PORT_SET =
		(NUM_PORTS >= MASK_W) ? '1 : MASK_W'((1 << NUM_PORTS) - 1);

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               psel         = 1'b0;
	logic               penable      = 1'b0;
	logic               pwrite       = 1'b0;
	logic [PADDR_W-1:0] paddr        = '0;
	logic [PDATA_W-1:0] pwdata       = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               frame_valid  = 1'b0;
	logic               frame_ready;
	frame_t             frame_in     = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	result_t            result_out;

	// Local copy of the forwarding table, kept in step with the block by
	// running every accepted frame through predict_forwarding.
	logic               seen_valid  [TABLE_ENTRIES];
	logic [MAC_W-1:0]   seen_mac    [TABLE_ENTRIES];
	logic [PORT_W-1:0]  seen_port   [TABLE_ENTRIES];
	logic [TICK_W-1:0]  seen_expiry [TABLE_ENTRIES];

	// Local copy of the configuration registers.
	logic [AGING_W-1:0] aging_setting = AGING_RESET;
	logic [MASK_W-1:0]  ports_setting = PORTS_RESET;

	// Decisions predicted for frames that were accepted but whose result
	// transfer has not arrived yet, oldest first.
	result_t expected_results [$];

	int error_count = 0;
	int cycle_count = 0;

	// Percent of cycles in which the frame source holds off and the result
	// sink refuses a transfer. They are changed between test phases.
	int idle_pct  = 0;
	int stall_pct = 0;

	mac_learning_forward_table #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.NUM_PORTS     (NUM_PORTS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame        (frame_in),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// An entry is live while its expiry lies strictly ahead of now, judged
	// as a signed 32-bit difference so that the tick counter may wrap.
	function automatic bit still_live(input logic [TICK_W-1:0] expiry,
			input logic [TICK_W-1:0] now);
		logic [TICK_W-1:0] diff;
		diff = expiry - now;
		return (diff != '0) && !diff[TICK_W-1];
	endfunction

	function automatic logic [MASK_W-1:0] port_bit(input logic [PORT_W-1:0] port);
		return (port < NUM_PORTS) ? MASK_W'(1) << port : '0;
	endfunction

	// Learns the source of one frame into the local table, looks up its
	// destination and returns the decision that the block must produce.
	function automatic result_t predict_forwarding(input frame_t f);
		int      match;
		int      empty_slot;
		int      stale_slot;
		int      slot;
		result_t r;
		match         = -1;
		empty_slot    = -1;
		stale_slot    = -1;
		r.decision    = DEC_FLOOD;
		r.egress_mask = '0;
		r.learn_skipped = 1'b0;

		// A known source keeps its slot even when that entry has expired.
		// A new source takes the lowest free slot, else the lowest expired one.
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (seen_valid[i]) begin
				if (seen_mac[i] == f.src_mac) begin
					if (match < 0)
						match = i;
				end else if (stale_slot < 0 && !still_live(seen_expiry[i], f.now_ticks)) begin
					stale_slot = i;
				end
			end else if (empty_slot < 0) begin
				empty_slot = i;
			end
		end
		slot = (match >= 0) ? match : ((empty_slot >= 0) ? empty_slot : stale_slot);
		if (slot >= 0) begin
			seen_valid[slot]  = 1'b1;
			seen_mac[slot]    = f.src_mac;
			seen_port[slot]   = f.ingress_port;
			seen_expiry[slot] = f.now_ticks + TICK_W'(aging_setting);
		end else begin
			r.learn_skipped = 1'b1;
		end

		// Group and broadcast destinations are never looked up. An expired
		// hit is dropped from the table and treated as a miss.
		if (!f.dst_mac[GROUP_BIT]) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (seen_valid[i] && seen_mac[i] == f.dst_mac) begin
					if (still_live(seen_expiry[i], f.now_ticks)) begin
						if (seen_port[i] == f.ingress_port) begin
							r.decision = DEC_FILTER;
						end else begin
							r.decision    = DEC_FORWARD;
							r.egress_mask = port_bit(seen_port[i]);
						end
					end else begin
						seen_valid[i] = 1'b0;
					end
					break;
				end
			end
		end
		if (r.decision == DEC_FLOOD)
			r.egress_mask = ports_setting & PORT_SET & ~port_bit(f.ingress_port);
		return r;
	endfunction

	function automatic frame_t frame_of(input logic [MAC_W-1:0] src,
			input logic [MAC_W-1:0] dst, input logic [PORT_W-1:0] port,
			input logic [TICK_W-1:0] now);
		frame_t f;
		f.src_mac      = src;
		f.dst_mac      = dst;
		f.ingress_port = port;
		f.now_ticks    = now;
		return f;
	endfunction

	function automatic logic [MAC_W-1:0] random_mac();
		return MAC_W'({$urandom, $urandom});
	endfunction

	// Offers one frame and returns at the edge where its transfer happens.
	// Valid is only lowered when an idle gap is actually taken, so that a
	// back-to-back frame keeps valid high without a glitch in the same step.
	task automatic send_frame(input frame_t f);
		if ($urandom_range(99) < idle_pct) begin
			frame_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		frame_valid <= 1'b1;
		frame_in    <= f;
		do
			@(posedge clk);
		while (frame_ready !== 1'b1);
		expected_results = {expected_results, predict_forwarding(f)};
	endtask

	// Stops offering frames and waits until every predicted result has come
	// back. Each frame yields exactly one result, so the block is idle then.
	task automatic wait_for_results();
		frame_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// One APB write: a setup phase, an access phase that completes on pready,
	// then an idle phase with the bus released.
	task automatic program_register(input logic reg_sel, input logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({reg_sel, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_sel == REG_AGING)
			aging_setting = value[AGING_W-1:0];
		else
			ports_setting = value[MASK_W-1:0];
		@(posedge clk);
	endtask

	// Every result transfer is compared with the oldest prediction. The sink
	// side of the handshake is driven from the same block so that ready and
	// the comparison always agree on which edge a transfer happened.
	always @(posedge clk) begin : check_results
		result_t want;
		if (result_valid === 1'b1 && result_ready === 1'b1) begin
			if (expected_results.size() == 0) begin
				$error("result transfer arrived with no frame outstanding");
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (result_out.decision !== want.decision) begin
					$error("decision: expected %0d, got %0d", want.decision,
						result_out.decision);
					error_count++;
				end
				if (result_out.egress_mask !== want.egress_mask) begin
					$error("egress_mask: expected %h, got %h", want.egress_mask,
						result_out.egress_mask);
					error_count++;
				end
				if (result_out.learn_skipped !== want.learn_skipped) begin
					$error("learn_skipped: expected %0d, got %0d", want.learn_skipped,
						result_out.learn_skipped);
					error_count++;
				end
			end
		end
		result_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Basic decisions under the reset configuration: forward, filter, flood
	// for broadcast, group and unknown destinations, an expired hit, a known
	// source refreshed after it expired, and a tick counter that wraps.
	task automatic test_directed_forwarding();
		logic [MAC_W-1:0] mac_a;
		logic [MAC_W-1:0] mac_b;
		logic [MAC_W-1:0] mac_c;
		logic [MAC_W-1:0] mac_d;
		logic [MAC_W-1:0] mac_e;
		frame_t           f;
		mac_a = 48'h0200_0000_000A;
		mac_b = 48'h0200_0000_000B;
		mac_c = 48'h0200_0000_000C;
		mac_d = 48'h0200_0000_000D;
		mac_e = 48'h0200_0000_000E;
		idle_pct  = 0;
		stall_pct = 0;
		// The all-zero address is learned on port 0 and then found from
		// port 7 at the top of the tick range, just before the wrap.
		send_frame(frame_of('0, BCAST_MAC, 3'd0, 32'd0));
		send_frame(frame_of(mac_a, '0, 3'd7, 32'hFFFF_FFFF));
		send_frame(frame_of(mac_b, mac_a, 3'd3, 32'd5));
		send_frame(frame_of(mac_a, mac_b, 3'd7, 32'd6));
		// The destination sits on the ingress port, so the frame is filtered.
		send_frame(frame_of(mac_c, mac_a, 3'd7, 32'd7));
		send_frame(frame_of(mac_b, 48'h0100_5E00_0001, 3'd3, 32'd8));
		send_frame(frame_of(BCAST_MAC, 48'h0011_2233_4455, 3'd5, 32'd9));
		// Address A expires exactly at this tick: it is dropped and flooded,
		// and the next lookup misses.
		send_frame(frame_of(mac_d, mac_a, 3'd1, 32'd306));
		send_frame(frame_of(mac_d, mac_a, 3'd2, 32'd307));
		// C is refreshed although its entry expired; D is found expired.
		send_frame(frame_of(mac_c, mac_d, 3'd4, 32'd1000));
		send_frame(frame_of(mac_e, mac_c, 3'd6, 32'd1001));
		send_frame(frame_of(BCAST_MAC, BCAST_MAC, 3'd6, 32'd1002));
		f = frame_of(random_mac(), random_mac(), PORT_W'($urandom), $urandom);
		f.dst_mac[GROUP_BIT] = 1'b0;
		send_frame(f);
	endtask

	// Register extremes: an aging time of zero, of one tick and of the
	// largest value, an empty and a sparse port mask, and forwarding to a
	// port that is not present.
	task automatic test_config_extremes();
		logic [MAC_W-1:0] mac_f;
		logic [MAC_W-1:0] mac_g;
		logic [MAC_W-1:0] mac_h;
		logic [MAC_W-1:0] mac_j;
		logic [MAC_W-1:0] mac_k;
		mac_f = 48'h0A00_0000_00F0;
		mac_g = 48'h0A00_0000_00F1;
		mac_h = 48'h0A00_0000_00F2;
		mac_j = 48'h0A00_0000_00F3;
		mac_k = 48'h0A00_0000_00F4;
		wait_for_results();
		program_register(REG_AGING, 32'd0);
		program_register(REG_PORTS, 32'h00);
		// With no aging the source is stale by the time it is looked up,
		// and with no ports present the flood reaches nobody.
		send_frame(frame_of(mac_f, mac_f, 3'd2, 32'd2000));
		wait_for_results();
		program_register(REG_AGING, 32'd1);
		program_register(REG_PORTS, 32'h5A);
		send_frame(frame_of(mac_g, BCAST_MAC, 3'd0, 32'd3000));
		// Port 0 is absent from the mask but still gets the forward.
		send_frame(frame_of(mac_h, mac_g, 3'd4, 32'd3000));
		send_frame(frame_of(mac_h, mac_g, 3'd4, 32'd3001));
		wait_for_results();
		program_register(REG_AGING, 32'h7FFF_FFFF);
		program_register(REG_PORTS, 32'hFF);
		send_frame(frame_of(mac_j, BCAST_MAC, 3'd7, 32'h8000_0000));
		send_frame(frame_of(mac_k, mac_j, 3'd0, 32'h8000_0001));
		send_frame(frame_of(mac_k, mac_j, 3'd1, 32'h8000_0000 + 32'h7FFF_FFFF));
	endtask

	// Fills every slot with live entries so that further new sources are
	// skipped, refreshes a known source while full, and then lets the oldest
	// entries age out so that the lowest expired slot is reused.
	task automatic test_table_full();
		logic [MAC_W-1:0]  learned [72];
		logic [TICK_W-1:0] base;
		frame_t            f;
		wait_for_results();
		idle_pct  = 16;
		stall_pct = 16;
		program_register(REG_AGING, 32'd100000);
		program_register(REG_PORTS, 32'hFF);
		base = 32'h1000_0000;
		for (int i = 0; i < 72; i++) begin
			learned[i]            = random_mac();
			learned[i][GROUP_BIT] = 1'b0;
			f = frame_of(learned[i], learned[$urandom_range(i)], PORT_W'($urandom),
				base + TICK_W'(i));
			send_frame(f);
		end
		send_frame(frame_of(learned[3], learned[70], 3'd5, base + 32'd80));
		for (int i = 0; i < 8; i++) begin
			f = frame_of(random_mac(), learned[i * 9], PORT_W'($urandom),
				base + 32'd100000 + TICK_W'(2 * i));
			send_frame(f);
		end
	endtask

	// Traffic from a pool of stations with a home port each. Most frames go
	// between stations of the pool; some go to unknown, group or broadcast
	// addresses, stations move between ports, and time mostly creeps forward
	// with occasional jumps so that entries expire at a steady rate.
	task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
			input int items);
		logic [MAC_W-1:0]  pool_mac  [96];
		logic [PORT_W-1:0] pool_port [96];
		int                pool_size;
		int                pick;
		int                roll;
		logic [TICK_W-1:0] now;
		frame_t            f;
		wait_for_results();
		idle_pct  = sender_idle;
		stall_pct = receiver_stall;
		case ($urandom_range(3))
			0: begin
				program_register(REG_AGING, $urandom_range(16, 1));
			end
			1: begin
				program_register(REG_AGING, $urandom_range(2000, 1));
			end
			2: begin
				program_register(REG_AGING, $urandom_range(32'h7FFF_FFFF, 1));
			end
			default: begin
				program_register(REG_AGING, 32'h7FFF_FFFF);
			end
		endcase
		program_register(REG_PORTS, $urandom_range(255));

		// A pool larger than the table lets it fill up under long aging.
		pool_size = $urandom_range(96, 8);
		for (int i = 0; i < pool_size; i++) begin
			pool_mac[i] = random_mac();
			if ($urandom_range(9) != 0)
				pool_mac[i][GROUP_BIT] = 1'b0;
			pool_port[i] = PORT_W'($urandom);
		end
		now = $urandom;

		repeat (items) begin
			roll = $urandom_range(99);
			if (roll < 80)
				now = now + $urandom_range(8);
			else if (roll < 95)
				now = now + $urandom_range(600);
			else
				now = $urandom;

			pick = $urandom_range(pool_size - 1);
			if ($urandom_range(9) == 0)
				pool_port[pick] = PORT_W'($urandom);
			f.src_mac      = pool_mac[pick];
			f.ingress_port = pool_port[pick];
			f.now_ticks    = now;

			roll = $urandom_range(99);
			if (roll < 70) begin
				f.dst_mac = pool_mac[$urandom_range(pool_size - 1)];
			end else if (roll < 80) begin
				f.dst_mac = random_mac();
			end else if (roll < 90) begin
				f.dst_mac = BCAST_MAC;
			end else begin
				f.dst_mac            = random_mac();
				f.dst_mac[GROUP_BIT] = 1'b1;
			end
			// Now and then a stranger sends, which churns the table.
			if ($urandom_range(19) == 0)
				f.src_mac = random_mac();
			send_frame(f);
		end
	endtask

	// Watchdog: a run that has not finished by the limit has hung.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		for (int i = 0; i < TABLE_ENTRIES; i++)
			seen_valid[i] = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_forwarding();
		test_config_extremes();
		test_table_full();
		// Handshake phases: no idling, an idle source, a stalling sink, both.
		test_random_traffic(0, 0, 212);
		test_random_traffic(87, 0, 212);
		test_random_traffic(0, 87, 212);
		test_random_traffic(16, 16, 212);

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
